/* rtl/jsd_pkg.sv */
// Package: types, constants and state codes for the job sequencing block
`timescale 1ns / 1ps
package jsd_pkg;

    localparam int MAX_JOBS  = 32;
    localparam int MAX_SLOTS = 32;
    localparam int JOB_IDX_W = $clog2(MAX_JOBS);
    localparam int JOB_CNT_W = $clog2(MAX_JOBS + 1);
    localparam int SLOT_W    = 6;
    localparam int ID_W      = 16;
    localparam int PROFIT_W  = 16;
    localparam int TOTAL_W   = 21;
    localparam int SUM_W     = 22;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [TOTAL_W-1:0] PROFIT_LIMIT = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]     job_id;
        logic [PROFIT_W-1:0] job_profit;
        logic [SLOT_W-1:0]   job_deadline;
        logic                last_job;
    } t_job_in;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_number;
        logic [ID_W-1:0]    slot_job_id;
        logic               slot_filled;
        logic [TOTAL_W-1:0] total_profit;
        logic               jobs_dropped;
        logic               last_slot;
    } t_slot_out;

    // job passed from front to back, deadline already saturated
    typedef struct packed {
        logic [ID_W-1:0]     job_id;
        logic [PROFIT_W-1:0] job_profit;
        logic [SLOT_W-1:0]   job_deadline;
        logic                last_job;
        logic                store;
    } t_job_q;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PICK,
        ST_FIND,
        ST_EMIT,
        ST_CLEAR
    } t_state;

endpackage

/* rtl/jsd_front.sv */
// Front end: accepts job beats, saturates deadlines, flags overflow, fills a short queue
`timescale 1ns / 1ps
module jsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  jsd_pkg::t_job_in i_data,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output jsd_pkg::t_job_q o_q_data
);
    import jsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job_q             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;
    logic [JOB_CNT_W-1:0] r_seen, n_seen;
    t_job_q             w_job;
    logic               w_push, w_pop;

    // classify: saturate deadline, count jobs of the set to mark stores
    always_comb begin
        w_job.job_id     = i_data.job_id;
        w_job.job_profit = i_data.job_profit;
        w_job.job_deadline = (i_data.job_deadline > SLOT_W'(MAX_SLOTS)) ?
                             SLOT_W'(MAX_SLOTS) : i_data.job_deadline;
        w_job.last_job   = i_data.last_job;
        w_job.store      = (r_seen < JOB_CNT_W'(MAX_JOBS));
    end

    assign o_ready   = (r_cnt != (PTR_W+1)'(QUEUE_DEPTH));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_data  = r_mem[r_rd];

    always_comb begin
        n_seen = r_seen;
        if (w_push) begin
            if (i_data.last_job)
                n_seen = '0;
            else if (w_job.store)
                n_seen = r_seen + 1'b1;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
            if (w_push)
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (w_pop)
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wr] <= w_job;
    end

endmodule

/* rtl/jsd_back.sv */
// Back end: stores jobs, picks them in profit order, places them in slots, emits the schedule
`timescale 1ns / 1ps
module jsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  jsd_pkg::t_job_q   i_q_data,
    output logic              o_valid,
    input  logic              i_ready,
    output jsd_pkg::t_slot_out o_data
);
    import jsd_pkg::*;

    localparam int SIDX_W = $clog2(MAX_SLOTS + 1);

    // job store, one entry per stored job
    logic [ID_W-1:0]     r_ids   [MAX_JOBS];
    logic [PROFIT_W-1:0] r_prof  [MAX_JOBS];
    logic [SLOT_W-1:0]   r_dl    [MAX_JOBS];
    logic [MAX_JOBS-1:0] r_done;
    // slot table
    logic [ID_W-1:0]     r_slot_id [MAX_SLOTS + 1];
    logic [MAX_SLOTS:0]  r_used;

    t_state               r_state, n_state;
    logic [JOB_CNT_W-1:0] r_cnt;
    logic [JOB_IDX_W-1:0] r_scan;
    logic [JOB_IDX_W-1:0] r_best;
    logic                 r_have;
    logic [SLOT_W-1:0]    r_k;
    logic [SLOT_W-1:0]    r_latest;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_drop;
    logic [SLOT_W-1:0]    r_emit;
    logic                 r_out_v;
    t_slot_out            r_out;
    logic                 w_load, w_out_free, w_scan_end, w_better;
    logic [SIDX_W-1:0]    w_kidx, w_eidx;

    assign w_out_free = !r_out_v || i_ready;
    assign w_load     = i_q_valid && o_q_ready;
    assign w_scan_end = (JOB_CNT_W'(r_scan) == r_cnt - 1'b1);
    // strict greater keeps the earliest job among equal profits
    assign w_better   = !r_done[r_scan] && (!r_have || r_prof[r_scan] > r_prof[r_best]);
    assign w_kidx     = SIDX_W'(r_k);
    assign w_eidx     = SIDX_W'(r_emit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (w_load && i_q_data.last_job)
                n_state = ST_PICK;
            ST_PICK: if (r_cnt == '0 || (w_scan_end && !w_better && !r_have))
                n_state = ST_EMIT;
            else if (w_scan_end)
                n_state = ST_FIND;
            ST_FIND: if (r_k == '0 || !r_used[w_kidx])
                n_state = ST_PICK;
            ST_EMIT: if (r_latest == '0 || (w_out_free && r_emit == r_latest))
                n_state = ST_CLEAR;
            ST_CLEAR: n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs of the control
    always_comb begin
        o_q_ready = (r_state == ST_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_scan   <= '0;
            r_have   <= 1'b0;
            r_latest <= '0;
            r_sum    <= '0;
            r_drop   <= 1'b0;
            r_used   <= '0;
            r_done   <= '0;
            r_emit   <= SLOT_W'(1);
            r_out_v  <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            // output beat: load a new one when free, else drop it once taken
            if (r_state == ST_EMIT && r_latest != '0 && w_out_free)
                r_out_v <= 1'b1;
            else if (i_ready)
                r_out_v <= 1'b0;
            unique case (r_state)
                // load: store job beats
                ST_LOAD: begin
                    if (w_load) begin
                        if (i_q_data.store) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (i_q_data.job_deadline > r_latest)
                                r_latest <= i_q_data.job_deadline;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        r_scan <= '0;
                        r_have <= 1'b0;
                    end
                end
                // pick: scan for the best undone job, one entry a cycle
                ST_PICK: begin
                    if (r_cnt != '0) begin
                        if (w_better) begin
                            r_best <= r_scan;
                            r_have <= 1'b1;
                        end
                        if (w_scan_end) begin
                            r_scan <= '0;
                            if (w_better) begin
                                r_done[r_scan] <= 1'b1;
                                r_k <= (r_dl[r_scan] > r_latest) ? r_latest : r_dl[r_scan];
                            end else if (r_have) begin
                                r_done[r_best] <= 1'b1;
                                r_k <= (r_dl[r_best] > r_latest) ? r_latest : r_dl[r_best];
                            end
                        end else begin
                            r_scan <= r_scan + 1'b1;
                        end
                    end
                end
                // find: walk down from the deadline, one slot a cycle
                ST_FIND: begin
                    r_have <= 1'b0;
                    if (r_k != '0) begin
                        if (!r_used[w_kidx]) begin
                            r_used[w_kidx] <= 1'b1;
                            r_sum <= r_sum + SUM_W'(r_prof[r_best]);
                        end else begin
                            r_k <= r_k - 1'b1;
                        end
                    end
                end
                // emit one slot beat per cycle while the output is free
                ST_EMIT: begin
                    if (r_latest != '0 && w_out_free)
                        r_emit <= r_emit + 1'b1;
                end
                ST_CLEAR: begin
                    r_cnt    <= '0;
                    r_latest <= '0;
                    r_sum    <= '0;
                    r_drop   <= 1'b0;
                    r_used   <= '0;
                    r_done   <= '0;
                    r_emit   <= SLOT_W'(1);
                    r_have   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && w_load && i_q_data.store) begin
            r_ids[r_cnt[JOB_IDX_W-1:0]]  <= i_q_data.job_id;
            r_prof[r_cnt[JOB_IDX_W-1:0]] <= i_q_data.job_profit;
            r_dl[r_cnt[JOB_IDX_W-1:0]]   <= i_q_data.job_deadline;
        end
        if (r_state == ST_FIND && r_k != '0 && !r_used[w_kidx])
            r_slot_id[w_kidx] <= r_ids[r_best];
        if (r_state == ST_EMIT && r_latest != '0 && w_out_free) begin
            r_out.slot_number  <= r_emit;
            r_out.slot_filled  <= r_used[w_eidx];
            r_out.slot_job_id  <= r_used[w_eidx] ? r_slot_id[w_eidx] : '0;
            r_out.total_profit <= (r_sum > SUM_W'(PROFIT_LIMIT)) ?
                                  PROFIT_LIMIT : r_sum[TOTAL_W-1:0];
            r_out.jobs_dropped <= r_drop;
            r_out.last_slot    <= (r_emit == r_latest);
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

/* rtl/job_sequencing_deadlines_core.sv */
// Top level: greedy job sequencing with deadlines, front queue plus scheduling back end
//
//  channel  dir  handshake            payload
//  job in   in   i_valid / o_ready    i_data  (t_job_in)
//  slot out out  o_valid / i_ready    o_data  (t_slot_out)
//
// Jobs load at one beat a cycle through a two-entry queue while the back end is
// loading. On the last job the back end picks jobs in profit order, each pick a scan
// over every stored job, then walks down up to latest_deadline slots; latest_deadline beats go out.
// Reset is synchronous and clears all control state. A stalled output holds its beat.
`timescale 1ns / 1ps
module job_sequencing_deadlines_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jsd_pkg::t_job_in   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output jsd_pkg::t_slot_out o_data
);
    import jsd_pkg::*;

    logic   w_q_valid, w_q_ready;
    t_job_q w_q_data;

    jsd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_q_valid(w_q_valid), .i_q_ready(w_q_ready), .o_q_data(w_q_data)
    );

    jsd_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_ready(w_q_ready), .i_q_data(w_q_data),
        .o_valid, .i_ready, .o_data
    );

    // an empty slot always reports job id zero
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.slot_filled |-> o_data.slot_job_id == '0)
        else $error("empty slot carries a job id");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.slot_number != '0 && o_data.slot_number <= SLOT_W'(MAX_SLOTS))
        else $error("slot number out of range");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last_slot ##1 o_valid |->
        o_data.slot_number == $past(o_data.slot_number) + 1'b1)
        else $error("slot beats out of order");

endmodule
